// ===== rtl/ray_box_intersect_2d_assert.svh =====
// Assertion macros used by the ray/box intersection checker.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RAY_BOX_INTERSECT_2D_ASSERT_SVH
`define RAY_BOX_INTERSECT_2D_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RBI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbi assertion failed");

`endif

// ===== rtl/rbi_pkg.sv =====
// Shared types and constants for the ray/box intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps
package rbi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_ADDR_W    = 2;
  localparam int IN_DATA_W     = 128;
  localparam int OUT_DATA_W    = 40;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MIN_Y = 2'd1,
    REG_BOX_MAX_X = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } box_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] st_x;
    logic signed [COORD_W-1:0] st_y;
    logic signed [COORD_W-1:0] dr_x;
    logic signed [COORD_W-1:0] dr_y;
    logic                      qual_x;
    logic                      qual_y;
    logic                      neg_x;
    logic                      neg_y;
    logic                      fok_x;
    logic                      fok_y;
    logic                      in_both;
  } tag_t;

endpackage

// ===== rtl/rbi_udiv.sv =====
// Two-lane pipelined unsigned restoring divider, one quotient bit per stage.
// Carries an rbi_pkg::tag_t alongside each item; depends on rbi_pkg.
`timescale 1ns / 1ps
module rbi_udiv #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [rbi_pkg::COORD_W+FRAC_BITS-1:0] num_x,
  input  logic [rbi_pkg::COORD_W+FRAC_BITS-1:0] num_y,
  input  logic [rbi_pkg::COORD_W-1:0]           den_x,
  input  logic [rbi_pkg::COORD_W-1:0]           den_y,
  input  rbi_pkg::tag_t                         in_tag,
  output logic                                 out_vld,
  output logic [rbi_pkg::COORD_W+FRAC_BITS-1:0] quo_x,
  output logic [rbi_pkg::COORD_W+FRAC_BITS-1:0] quo_y,
  output rbi_pkg::tag_t                         out_tag
);

  localparam int DEN_W = rbi_pkg::COORD_W;
  localparam int NUM_W = DEN_W + FRAC_BITS;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
  } lane_t;

  function automatic lane_t div_step(input lane_t a);
    lane_t      b;
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic       ge;
    sh   = {a.rem, a.num[NUM_W-1]};
    diff = sh - {1'b0, a.den};
    ge   = (sh >= {1'b0, a.den});
    b.den = a.den;
    b.num = {a.num[NUM_W-2:0], 1'b0};
    b.quo = {a.quo[NUM_W-2:0], ge};
    b.rem = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    return b;
  endfunction

  lane_t         lx_r  [NUM_W];
  lane_t         ly_r  [NUM_W];
  rbi_pkg::tag_t tag_r [NUM_W];
  logic [NUM_W-1:0] vld_r;

  lane_t lx_in;
  lane_t ly_in;

  assign lx_in = '{num: num_x, quo: '0, rem: '0, den: den_x};
  assign ly_in = '{num: num_y, quo: '0, rem: '0, den: den_y};

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    lane_t         px;
    lane_t         py;
    rbi_pkg::tag_t pt;
    logic          pv;
    if (s == 0) begin : g_first
      assign px = lx_in;
      assign py = ly_in;
      assign pt = in_tag;
      assign pv = in_vld;
    end else begin : g_rest
      assign px = lx_r[s-1];
      assign py = ly_r[s-1];
      assign pt = tag_r[s-1];
      assign pv = vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx_r[s]  <= div_step(px);
        ly_r[s]  <= div_step(py);
        tag_r[s] <= pt;
      end
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign quo_x   = lx_r[NUM_W-1].quo;
  assign quo_y   = ly_r[NUM_W-1].quo;
  assign out_tag = tag_r[NUM_W-1];

endmodule

// ===== rtl/rbi_post.sv =====
// Axis choice, saturation, other-axis multiply and box test, three stages.
// Final stage is the output register; depends on rbi_pkg.
`timescale 1ns / 1ps
module rbi_post #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  rbi_pkg::box_t                        box,
  input  logic                                 in_vld,
  input  logic [rbi_pkg::COORD_W+FRAC_BITS-1:0] quo_x,
  input  logic [rbi_pkg::COORD_W+FRAC_BITS-1:0] quo_y,
  input  rbi_pkg::tag_t                         in_tag,
  output logic                                 out_vld,
  output logic                                 out_hit,
  output logic [rbi_pkg::COORD_W-1:0]           out_scale,
  output logic                                 out_sat
);

  localparam int CW    = rbi_pkg::COORD_W;
  localparam int NUM_W = CW + FRAC_BITS;
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(33'h0_7fff_ffff);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(33'h0_8000_0000);

  logic                 a_vld_r, a_any_r, a_inb_r, a_fok_r, a_ysel_r, a_sat_r;
  logic signed [CW-1:0] a_sc_r, a_st_r, a_dr_r;
  logic                 a_any_nxt, a_fok_nxt, a_ysel_nxt, a_sat_nxt, a_neg;
  logic signed [CW-1:0] a_sc_nxt;
  logic [NUM_W-1:0]     a_mag;

  always_comb begin
    a_ysel_nxt = in_tag.qual_y && (!in_tag.qual_x || (quo_y > quo_x));
    a_any_nxt  = in_tag.qual_x || in_tag.qual_y;
    a_mag      = a_ysel_nxt ? quo_y : quo_x;
    a_neg      = a_ysel_nxt ? in_tag.neg_y : in_tag.neg_x;
    a_fok_nxt  = a_ysel_nxt ? in_tag.fok_y : in_tag.fok_x;
    a_sat_nxt  = a_any_nxt && (a_neg ? (a_mag > NEG_LIM) : (a_mag > POS_LIM));
    if (!a_any_nxt) begin
      a_sc_nxt = '0;
    end else if (a_sat_nxt) begin
      a_sc_nxt = a_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (a_neg) begin
      a_sc_nxt = -$signed(a_mag[CW-1:0]);
    end else begin
      a_sc_nxt = $signed(a_mag[CW-1:0]);
    end
  end

  logic                     b_vld_r, b_any_r, b_inb_r, b_fok_r, b_ysel_r, b_sat_r;
  logic signed [CW-1:0]     b_sc_r, b_st_r;
  logic signed [2*CW-1:0]   b_prod_r;
  logic signed [2*CW-1:0]   b_prod_nxt;

  assign b_prod_nxt = a_sc_r * a_dr_r;

  logic signed [2*CW-1:0] c_sh;
  logic signed [2*CW:0]   c_pos, c_lo, c_hi;
  logic                   c_hit_nxt;

  always_comb begin
    c_sh  = b_prod_r >>> FRAC_BITS;
    c_pos = {{(CW+1){b_st_r[CW-1]}}, b_st_r} + {c_sh[2*CW-1], c_sh};
    c_lo  = b_ysel_r ? {{(CW+1){box.min_x[CW-1]}}, box.min_x}
                     : {{(CW+1){box.min_y[CW-1]}}, box.min_y};
    c_hi  = b_ysel_r ? {{(CW+1){box.max_x[CW-1]}}, box.max_x}
                     : {{(CW+1){box.max_y[CW-1]}}, box.max_y};
    c_hit_nxt = b_any_r ? (b_fok_r && (c_pos >= c_lo) && (c_pos <= c_hi)) : b_inb_r;
  end

  logic                 c_vld_r, c_hit_r, c_sat_r;
  logic [CW-1:0]        c_sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_any_r  <= a_any_nxt;
      a_inb_r  <= in_tag.in_both;
      a_fok_r  <= a_fok_nxt;
      a_ysel_r <= a_ysel_nxt;
      a_sat_r  <= a_sat_nxt;
      a_sc_r   <= a_sc_nxt;
      a_st_r   <= a_ysel_nxt ? in_tag.st_x : in_tag.st_y;
      a_dr_r   <= a_ysel_nxt ? in_tag.dr_x : in_tag.dr_y;
      b_any_r  <= a_any_r;
      b_inb_r  <= a_inb_r;
      b_fok_r  <= a_fok_r;
      b_ysel_r <= a_ysel_r;
      b_sat_r  <= a_sat_r;
      b_sc_r   <= a_sc_r;
      b_st_r   <= a_st_r;
      b_prod_r <= b_prod_nxt;
      c_hit_r  <= c_hit_nxt;
      c_sat_r  <= b_sat_r;
      c_sc_r   <= b_sc_r;
    end
  end

  assign out_vld   = c_vld_r;
  assign out_hit   = c_hit_r;
  assign out_scale = c_sc_r;
  assign out_sat   = c_sat_r;

endmodule

// ===== rtl/ray_box_intersect_2d.sv =====
// Top level of the ray/box intersection pipeline: box registers, face stage,
// divider and result stages. Depends on rbi_pkg, rbi_udiv and rbi_post.
//
//   port group   dir   content
//   in_*         in    start_x, start_y, dir_x, dir_y
//   out_*        out   hit, scale, scale_saturated
//   cfg_*        in    box register writes
//
// The pipeline has one face stage, 32 + FRAC_BITS divider stages and three
// result stages. One item is accepted every cycle unless the pipeline holds.
// Reset clears the box registers and all valid bits.
// When the output item is not taken, the whole pipeline holds.
`timescale 1ns / 1ps
module ray_box_intersect_2d #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x [31:0], start_y [63:32], dir_x [95:64], dir_y [127:96]
  input  logic [rbi_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hit [0], scale [32:1], scale_saturated [33], zero [39:34]
  output logic [rbi_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [rbi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rbi_pkg::COORD_W-1:0]       cfg_wdata
);

  localparam int CW    = rbi_pkg::COORD_W;
  localparam int NUM_W = CW + FRAC_BITS;

  rbi_pkg::box_t box_r;
  logic          en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
    end else if (cfg_we) begin
      case (rbi_pkg::cfg_reg_t'(cfg_addr))
        rbi_pkg::REG_BOX_MIN_X: box_r.min_x <= cfg_wdata;
        rbi_pkg::REG_BOX_MIN_Y: box_r.min_y <= cfg_wdata;
        rbi_pkg::REG_BOX_MAX_X: box_r.max_x <= cfg_wdata;
        rbi_pkg::REG_BOX_MAX_Y: box_r.max_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] stx, sty, drx, dry, facex, facey;
  logic signed [CW:0]   fx, fy;
  logic [CW-1:0]        fmx, fmy, dmx, dmy;
  logic                 blx, bly, abx, aby;
  rbi_pkg::tag_t        tag_nxt;

  always_comb begin
    stx = in_tdata[31:0];
    sty = in_tdata[63:32];
    drx = in_tdata[95:64];
    dry = in_tdata[127:96];
    blx = stx < box_r.min_x;
    bly = sty < box_r.min_y;
    abx = stx > box_r.max_x;
    aby = sty > box_r.max_y;
    facex = blx ? box_r.min_x : box_r.max_x;
    facey = bly ? box_r.min_y : box_r.max_y;
    fx  = {stx[CW-1], stx} - {facex[CW-1], facex};
    fy  = {sty[CW-1], sty} - {facey[CW-1], facey};
    fmx = fx[CW] ? CW'(-fx) : fx[CW-1:0];
    fmy = fy[CW] ? CW'(-fy) : fy[CW-1:0];
    dmx = drx[CW-1] ? -drx : drx;
    dmy = dry[CW-1] ? -dry : dry;
    tag_nxt.st_x    = stx;
    tag_nxt.st_y    = sty;
    tag_nxt.dr_x    = drx;
    tag_nxt.dr_y    = dry;
    tag_nxt.qual_x  = (blx || abx) && (drx != '0);
    tag_nxt.qual_y  = (bly || aby) && (dry != '0);
    tag_nxt.neg_x   = (blx == drx[CW-1]);
    tag_nxt.neg_y   = (bly == dry[CW-1]);
    tag_nxt.fok_x   = (facex >= box_r.min_x) && (facex <= box_r.max_x);
    tag_nxt.fok_y   = (facey >= box_r.min_y) && (facey <= box_r.max_y);
    tag_nxt.in_both = !(blx || abx) && !(bly || aby);
  end

  logic             p_vld_r;
  rbi_pkg::tag_t    p_tag_r;
  logic [NUM_W-1:0] p_numx_r, p_numy_r;
  logic [CW-1:0]    p_denx_r, p_deny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tag_r  <= tag_nxt;
      p_numx_r <= {fmx, {FRAC_BITS{1'b0}}};
      p_numy_r <= {fmy, {FRAC_BITS{1'b0}}};
      p_denx_r <= dmx;
      p_deny_r <= dmy;
    end
  end

  logic             d_vld;
  logic [NUM_W-1:0] d_qx, d_qy;
  rbi_pkg::tag_t    d_tag;

  rbi_udiv #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (p_vld_r),
    .num_x   (p_numx_r),
    .num_y   (p_numy_r),
    .den_x   (p_denx_r),
    .den_y   (p_deny_r),
    .in_tag  (p_tag_r),
    .out_vld (d_vld),
    .quo_x   (d_qx),
    .quo_y   (d_qy),
    .out_tag (d_tag)
  );

  logic          o_hit, o_sat;
  logic [CW-1:0] o_scale;

  rbi_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .box       (box_r),
    .in_vld    (d_vld),
    .quo_x     (d_qx),
    .quo_y     (d_qy),
    .in_tag    (d_tag),
    .out_vld   (out_tvalid),
    .out_hit   (o_hit),
    .out_scale (o_scale),
    .out_sat   (o_sat)
  );

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tdata = {6'b0, o_sat, o_scale, o_hit};

endmodule

// ===== rtl/rbi_checker.sv =====
// Port-level checks for ray_box_intersect_2d, bound to the top level.
// Depends on rbi_pkg and ray_box_intersect_2d_assert.svh.
`timescale 1ns / 1ps
`include "ray_box_intersect_2d_assert.svh"
module rbi_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rbi_pkg::OUT_DATA_W-1:0] out_tdata
);

  `RBI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `RBI_ASSERT_NOW(a_ready_flow, 1'b1, in_tready == (!out_tvalid || out_tready))

  `RBI_ASSERT_NOW(a_sat_limit, out_tvalid && out_tdata[33], (out_tdata[32:1] == 32'h7fff_ffff) || (out_tdata[32:1] == 32'h8000_0000))

endmodule

bind ray_box_intersect_2d rbi_checker u_rbi_checker (.*);

// ===== test/ray_box_intersect_2d_test.sv =====
// Self-checking testbench for ray_box_intersect_2d: rays against a box held in config.
// Holds its own fixed-point predictor and compares every result item in order.
// Depends on rbi_pkg and the ray_box_intersect_2d RTL.
`timescale 1ns / 1ps
module ray_box_intersect_2d_test;

  localparam int FRAC = 16;
  localparam int LAT = 36 + FRAC;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hit;
    logic [31:0] scale;
    logic        sat;
  } hit_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [rbi_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [rbi_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [rbi_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [rbi_pkg::COORD_W-1:0] cfg_wdata = '0;

  longint box_lo[2];
  longint box_hi[2];
  hit_t expected_hits[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;

  ray_box_intersect_2d i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint floor_shr(longint p);
    if (p >= 0) return p >>> FRAC;
    return -((-p + ((64'sd1 << FRAC) - 1)) >>> FRAC);
  endfunction

  function automatic hit_t predict_hit(logic signed [31:0] sx, logic signed [31:0] sy,
                                       logic signed [31:0] dx, logic signed [31:0] dy);
    longint st[2], dr[2], face[2];
    longint q, mag, best, qsel, pos, sc;
    int axis, n_inside, other;
    hit_t r;
    st[0] = sx; st[1] = sy; dr[0] = dx; dr[1] = dy;
    axis = -1; n_inside = 0; best = 0; qsel = 0;
    for (int i = 0; i < 2; i++) begin
      if (st[i] < box_lo[i]) face[i] = box_lo[i];
      else if (st[i] > box_hi[i]) face[i] = box_hi[i];
      else begin
        n_inside++;
        continue;
      end
      if (dr[i] == 0) continue;
      q = -(((st[i] - face[i]) * (64'sd1 << FRAC)) / dr[i]);
      mag = q < 0 ? -q : q;
      if (axis < 0 || mag > best) begin
        best = mag; qsel = q; axis = i;
      end
    end
    r = '0;
    if (axis < 0) begin
      r.hit = (n_inside == 2);
      return r;
    end
    sc = qsel;
    if (sc > 64'sd2147483647) begin
      sc = 64'sd2147483647; r.sat = 1;
    end else if (sc < -64'sd2147483648) begin
      sc = -64'sd2147483648; r.sat = 1;
    end
    other = axis ^ 1;
    pos = st[other] + floor_shr(sc * dr[other]);
    r.hit = face[axis] >= box_lo[axis] && face[axis] <= box_hi[axis] &&
            pos >= box_lo[other] && pos <= box_hi[other];
    r.scale = sc[31:0];
    return r;
  endfunction

  task automatic idle_burst(input bit allow);
    if (allow && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_ray(input logic [31:0] sx, input logic [31:0] sy,
                          input logic [31:0] dx, input logic [31:0] dy);
    idle_burst(1);
    in_tvalid <= 1;
    in_tdata <= {dy, dx, sy, sx};
    expected_hits.push_back(predict_hit(sx, sy, dx, dy));
    do @(posedge clk); while (!in_tready);
  endtask

  always begin
    @(posedge clk);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        hit_t e;
        e = expected_hits.pop_front();
        if (out_tdata[0] !== e.hit || out_tdata[32:1] !== e.scale ||
            out_tdata[33] !== e.sat || out_tdata[39:34] !== '0) begin
          $display("%0t: mismatch expected hit %0b scale %h sat %0b, actual %h",
                   $time, e.hit, e.scale, e.sat, out_tdata);
          errors++;
        end
      end
    end
    if (quiet || $urandom_range(0, 4) != 0) out_tready <= 1;
    else out_tready <= 0;
  end

  task automatic drain_pipeline();
    in_tvalid <= 0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_box(input logic signed [31:0] lx, input logic signed [31:0] ly,
                           input logic signed [31:0] hx, input logic signed [31:0] hy);
    rbi_pkg::cfg_reg_t idx[4];
    logic [31:0] val[4];
    idx = '{rbi_pkg::REG_BOX_MIN_X, rbi_pkg::REG_BOX_MIN_Y,
            rbi_pkg::REG_BOX_MAX_X, rbi_pkg::REG_BOX_MAX_Y};
    val = '{lx, ly, hx, hy};
    for (int k = 0; k < 4; k++) begin
      cfg_we <= 1; cfg_addr <= idx[k]; cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we <= 0;
    box_lo[0] = lx; box_lo[1] = ly; box_hi[0] = hx; box_hi[1] = hy;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return $urandom_range(0, 2) - 1;
      default: return ($urandom_range(0, 40) - 20) << 16 | $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic test_reset_box();
    send_ray(0, 0, 0, 0);
    send_ray(32'h10000, 0, 32'hffff0000, 0);
    send_ray(32'h10000, 32'h10000, 32'h10000, 32'h10000);
    drain_pipeline();
  endtask

  task automatic test_directed();
    write_box(-(5 << 16), -(3 << 16), 5 << 16, 3 << 16);
    send_ray(0, 0, 1 << 16, 0);
    send_ray(-(10 << 16), 0, 1 << 16, 0);
    send_ray(-(10 << 16), 10 << 16, 1 << 16, -(1 << 16));
    send_ray(10 << 16, 10 << 16, 1 << 16, 1 << 16);
    send_ray(-(10 << 16), 0, 0, 1 << 16);
    send_ray(-(10 << 16), 20 << 16, 0, 0);
    send_ray(10 << 16, 0, 32'hffff_ffff, 0);
    send_ray(32'h8000_0000, 32'h7fff_ffff, 1, 1);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_ray(-(8 << 16), 8 << 16, 1 << 16, -(1 << 16));
    send_ray(-(8 << 16), 6 << 16, 3 << 16, 32'hffff_fffd);
    send_ray(20 << 16, 1 << 16, -(3 << 16), 0);
    drain_pipeline();
    write_box(5 << 16, 5 << 16, -(5 << 16), -(5 << 16));
    send_ray(0, 0, 1 << 16, 1 << 16);
    send_ray(10 << 16, 10 << 16, -(1 << 16), -(1 << 16));
    send_ray(-(10 << 16), 0, 1 << 16, 0);
    drain_pipeline();
    write_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_ray(12345, -678, 3, 4);
    drain_pipeline();
  endtask

  task automatic test_random_rays(input int count);
    for (int n = 0; n < count; n++)
      send_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_random_boxes();
    logic signed [31:0] a, b;
    for (int p = 0; p < 4; p++) begin
      a = rand_coord(); b = rand_coord();
      if (p != 3 && a > b) begin
        logic signed [31:0] t;
        t = a; a = b; b = t;
      end
      write_box(a, -(2 << 16) - $urandom_range(0, 1 << 20), b, 2 << 16);
      if (p == 3) quiet = 1;
      test_random_rays(100);
      drain_pipeline();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    box_lo = '{0, 0};
    box_hi = '{0, 0};
    test_reset_box();
    test_directed();
    test_random_boxes();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== ray_box_intersect_2d.f =====
+incdir+rtl
rtl/rbi_pkg.sv
rtl/rbi_udiv.sv
rtl/rbi_post.sv
rtl/ray_box_intersect_2d.sv
rtl/rbi_checker.sv
test/ray_box_intersect_2d_test.sv
